// File: rtl/core/cnm_pkg.sv
// shared types, constants and the sine table builder for the complex nco mixer
`timescale 1ns / 1ps

package cnm_pkg;

   // quadrant of the phase, taken from the top two phase bits
   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } cnm_quad_type;

   // per-sample control that travels from the front end to the back end
   typedef struct packed {
      logic         last;
      logic         bypass;
      cnm_quad_type quad;
   } cnm_ctrl_type;

   // occupancy flags of the decoupling queue
   typedef struct packed {
      logic full;
      logic empty;
   } cnm_queue_status_type;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int CSR_WIDTH      = 32;

   // pi/2 in q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // taylor series divisors (2n)(2n+1) for n = 1 .. 19
   localparam longint unsigned TAYLOR_DIV [1:19] = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812,
      64'd930, 64'd1056, 64'd1190, 64'd1332, 64'd1482
   };

   // q15 quarter-wave entry sin(k*pi/(2N)), evaluated at elaboration only
   function automatic logic [15:0] sin_entry(input int unsigned addr_bits,
                                             input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned e;
      x    = (HALF_PI_Q30 * longint'(k)) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n < 20; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      e = (sum + 64'd16384) >> 15;
      if (e > 64'd32768) begin
         e = 64'd32768;
      end
      return e[15:0];
   endfunction

endpackage

// File: rtl/core/cnm_front.sv
// front end: step register, phase accumulator and per-sample classification
`timescale 1ns / 1ps

module cnm_front #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int PHASE_WIDTH     = 32,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [cnm_pkg::CSR_WIDTH-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_im,
   input  logic                                req_last_in,
   output logic                                push_valid,
   input  logic                                push_ready,
   output cnm_pkg::cnm_ctrl_type               push_ctrl,
   output logic [TABLE_ADDR_BITS-1:0]          push_index,
   output logic signed [SAMPLE_WIDTH-1:0]      push_re,
   output logic signed [SAMPLE_WIDTH-1:0]      push_im
);
   import cnm_pkg::*;

   logic [PHASE_WIDTH-1:0] phase_ff;
   logic [PHASE_WIDTH-1:0] phase_in;
   logic [PHASE_WIDTH-1:0] step_ff;
   logic [PHASE_WIDTH-1:0] step_in;
   logic signed [CSR_WIDTH-1:0] step_wr;
   logic                   accept;

   // step register, sign-extended or wrapped to the phase width
   assign step_wr = csr_write_data;
   assign step_in = csr_write_en ? PHASE_WIDTH'(step_wr) : step_ff;

   // handshake straight into the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // phase advances once per transfer; a zero step leaves it unchanged
   assign phase_in = accept ? (phase_ff + step_ff) : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // classify: table address, quadrant, and zero-step bypass
   assign push_ctrl.last   = req_last_in;
   assign push_ctrl.bypass = (step_ff == '0);
   assign push_ctrl.quad   = cnm_quad_type'(phase_ff[PHASE_WIDTH-1 -: 2]);
   assign push_index       = phase_ff[PHASE_WIDTH-3 -: TABLE_ADDR_BITS];
   assign push_re          = req_sample_re;
   assign push_im          = req_sample_im;

endmodule

// File: rtl/core/cnm_queue.sv
// short fifo that decouples the front end from the back end
`timescale 1ns / 1ps

module cnm_queue #(
   parameter int WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  logic [WIDTH-1:0]              push_data,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output logic [WIDTH-1:0]              pop_data,
   output cnm_pkg::cnm_queue_status_type status
);
   import cnm_pkg::*;

   logic [WIDTH-1:0]          store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;
   logic                      do_push;
   logic                      do_pop;

   assign status.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   assign push_ready = !status.full;
   assign pop_valid  = !status.empty;
   assign pop_data   = store_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/cnm_back.sv
// back end: sine table read, complex multiply, rounding, saturation, output register
`timescale 1ns / 1ps

module cnm_back #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  cnm_pkg::cnm_ctrl_type            pop_ctrl,
   input  logic [TABLE_ADDR_BITS-1:0]       pop_index,
   input  logic signed [SAMPLE_WIDTH-1:0]   pop_re,
   input  logic signed [SAMPLE_WIDTH-1:0]   pop_im,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_mixed_re,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_mixed_im,
   output logic                             rsp_last_out
);
   import cnm_pkg::*;

   localparam int TabN = 1 << TABLE_ADDR_BITS;
   localparam int ProdW = SAMPLE_WIDTH + 17;
   localparam int SumW  = SAMPLE_WIDTH + 18;
   localparam int ScW   = SAMPLE_WIDTH + 3;
   localparam logic [TABLE_ADDR_BITS:0] TabNVec = (TABLE_ADDR_BITS+1)'(TabN);
   localparam logic signed [SumW-1:0]  RoundBias = SumW'(1 << 14);
   localparam logic signed [SAMPLE_WIDTH-1:0] SatMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SatMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // quarter-wave sine rom, entries 0 .. N
   logic [15:0] sin_rom [0:TabN];

   for (genvar k = 0; k <= TabN; k++) begin : g_rom
      localparam logic [15:0] EntryVal = sin_entry(TABLE_ADDR_BITS, k);
      assign sin_rom[k] = EntryVal;
   end

   // stage valids and flow control
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s2_free;
   logic s1_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign pop_ready = s1_free;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= pop_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage 1: registered table reads at i and N-i
   logic [TABLE_ADDR_BITS:0]        comp_index;
   logic [15:0]                     rom_a_ff;
   logic [15:0]                     rom_b_ff;
   logic signed [SAMPLE_WIDTH-1:0]  re1_ff;
   logic signed [SAMPLE_WIDTH-1:0]  im1_ff;
   cnm_ctrl_type                    ctrl1_ff;

   assign comp_index = TabNVec - {1'b0, pop_index};

   always_ff @(posedge clock) begin
      if (s1_free) begin
         rom_a_ff <= sin_rom[{1'b0, pop_index}];
         rom_b_ff <= sin_rom[comp_index];
         re1_ff   <= pop_re;
         im1_ff   <= pop_im;
         ctrl1_ff <= pop_ctrl;
      end
   end

   // stage 2: quadrant folding and the four products
   logic signed [16:0]              tab_a;
   logic signed [16:0]              tab_b;
   logic signed [16:0]              sin_val;
   logic signed [16:0]              cos_val;
   logic signed [ProdW-1:0]         p_rc_ff;
   logic signed [ProdW-1:0]         p_is_ff;
   logic signed [ProdW-1:0]         p_rs_ff;
   logic signed [ProdW-1:0]         p_ic_ff;
   logic signed [SAMPLE_WIDTH-1:0]  re2_ff;
   logic signed [SAMPLE_WIDTH-1:0]  im2_ff;
   cnm_ctrl_type                    ctrl2_ff;

   assign tab_a = {1'b0, rom_a_ff};
   assign tab_b = {1'b0, rom_b_ff};

   always_comb begin
      unique case (ctrl1_ff.quad)
         QUAD_0: begin
            sin_val = tab_a;
            cos_val = tab_b;
         end
         QUAD_1: begin
            sin_val = tab_b;
            cos_val = -tab_a;
         end
         QUAD_2: begin
            sin_val = -tab_a;
            cos_val = -tab_b;
         end
         QUAD_3: begin
            sin_val = -tab_b;
            cos_val = tab_a;
         end
         default: begin
            sin_val = tab_a;
            cos_val = tab_b;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         p_rc_ff  <= re1_ff * cos_val;
         p_is_ff  <= im1_ff * sin_val;
         p_rs_ff  <= re1_ff * sin_val;
         p_ic_ff  <= im1_ff * cos_val;
         re2_ff   <= re1_ff;
         im2_ff   <= im1_ff;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   // stage 3: sum, round half up, saturate, or pass through on zero step
   logic signed [SumW-1:0]          sum_re;
   logic signed [SumW-1:0]          sum_im;
   logic [ScW-1:0]                  sc_re;
   logic [ScW-1:0]                  sc_im;
   logic signed [SAMPLE_WIDTH-1:0]  sat_re;
   logic signed [SAMPLE_WIDTH-1:0]  sat_im;
   logic signed [SAMPLE_WIDTH-1:0]  mixed_re_ff;
   logic signed [SAMPLE_WIDTH-1:0]  mixed_im_ff;
   logic                            last_ff;

   assign sum_re = SumW'(p_rc_ff) - SumW'(p_is_ff) + RoundBias;
   assign sum_im = SumW'(p_rs_ff) + SumW'(p_ic_ff) + RoundBias;
   assign sc_re  = sum_re[SumW-1:15];
   assign sc_im  = sum_im[SumW-1:15];

   // in range when the bits above the sample msb are all copies of the sign
   always_comb begin
      if ((&sc_re[ScW-1:SAMPLE_WIDTH-1]) || !(|sc_re[ScW-1:SAMPLE_WIDTH-1])) begin
         sat_re = sc_re[SAMPLE_WIDTH-1:0];
      end else begin
         sat_re = sc_re[ScW-1] ? SatMin : SatMax;
      end
      if ((&sc_im[ScW-1:SAMPLE_WIDTH-1]) || !(|sc_im[ScW-1:SAMPLE_WIDTH-1])) begin
         sat_im = sc_im[SAMPLE_WIDTH-1:0];
      end else begin
         sat_im = sc_im[ScW-1] ? SatMin : SatMax;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         mixed_re_ff <= ctrl2_ff.bypass ? re2_ff : sat_re;
         mixed_im_ff <= ctrl2_ff.bypass ? im2_ff : sat_im;
         last_ff     <= ctrl2_ff.last;
      end
   end

   assign rsp_mixed_re = mixed_re_ff;
   assign rsp_mixed_im = mixed_im_ff;
   assign rsp_last_out = last_ff;

endmodule

// File: rtl/core/complex_nco_mixer_core.sv
// complex nco mixer top level: front end, queue and back end
`timescale 1ns / 1ps
// path: req, queue entry, stage 1, stage 2, output register, then rsp
// throughput: one sample per clock when rsp_ready does not stall, carried by four
// parallel multipliers and a two-port registered read of the quarter-wave sine rom
// reset (synchronous): phase accumulator and step cleared, queue and pipeline emptied
// the sine rom is constant and needs no fill after reset

module complex_nco_mixer_core #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int PHASE_WIDTH     = 32,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [31:0]                     csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_im,
   input  logic                            req_last_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_mixed_re,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_mixed_im,
   output logic                            rsp_last_out
);
   import cnm_pkg::*;

   localparam int CtrlW  = $bits(cnm_ctrl_type);
   localparam int QueueW = CtrlW + TABLE_ADDR_BITS + 2 * SAMPLE_WIDTH;

   logic                            push_valid;
   logic                            push_ready;
   cnm_ctrl_type                    push_ctrl;
   logic [TABLE_ADDR_BITS-1:0]      push_index;
   logic signed [SAMPLE_WIDTH-1:0]  push_re;
   logic signed [SAMPLE_WIDTH-1:0]  push_im;
   logic [QueueW-1:0]               push_data;

   logic                            pop_valid;
   logic                            pop_ready;
   logic [QueueW-1:0]               pop_data;
   cnm_ctrl_type                    pop_ctrl;
   logic [TABLE_ADDR_BITS-1:0]      pop_index;
   logic signed [SAMPLE_WIDTH-1:0]  pop_re;
   logic signed [SAMPLE_WIDTH-1:0]  pop_im;
   cnm_queue_status_type            q_status;

   // front end: accepts and classifies samples
   cnm_front #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .PHASE_WIDTH     (PHASE_WIDTH),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_re  (req_sample_re),
      .req_sample_im  (req_sample_im),
      .req_last_in    (req_last_in),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_ctrl      (push_ctrl),
      .push_index     (push_index),
      .push_re        (push_re),
      .push_im        (push_im)
   );

   assign push_data = {push_ctrl, push_index, push_re, push_im};

   // decoupling queue
   cnm_queue #(
      .WIDTH (QueueW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   assign {pop_ctrl, pop_index, pop_re, pop_im} = pop_data;

   // back end: table, multiply, round and saturate, or pass through on zero step
   cnm_back #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_ctrl     (pop_ctrl),
      .pop_index    (pop_index),
      .pop_re       (pop_re),
      .pop_im       (pop_im),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_mixed_re (rsp_mixed_re),
      .rsp_mixed_im (rsp_mixed_im),
      .rsp_last_out (rsp_last_out)
   );

   // back end never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> !q_status.empty)
      else $error("back end popped an empty queue");

   // a transfer on req always finds room in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !q_status.full)
      else $error("sample accepted while queue full");

   // no result is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule
